// ===== rtl/nssc_pkg.sv =====
// Shared types, constants and NAL header classification for the SAP classifier.
package nssc_pkg;

  localparam int unsigned DATA_W      = 8;
  localparam int unsigned LEN_W       = 32;
  localparam int unsigned CNT_W       = 3;
  localparam int unsigned CLS_W       = 2;
  localparam int unsigned APB_DATA_W  = 32;
  localparam int unsigned APB_ADDR_W  = 3;

  localparam logic [CNT_W-1:0] MAX_LENGTH_BYTES = 3'd4;
  localparam logic [CNT_W-1:0] LFB_RESET        = 3'd4;

  // register select bit of paddr (registers at byte 0 and 4)
  localparam logic REG_LENGTH_FIELD_BYTES = 1'b0;
  localparam logic REG_HEVC_MODE          = 1'b1;

  // AVC NAL unit types
  localparam logic [4:0] AVC_IDR    = 5'd5;
  localparam logic [4:0] AVC_SEI    = 5'd6;
  localparam logic [4:0] AVC_AUD    = 5'd9;
  localparam logic [4:0] AVC_FILLER = 5'd12;

  // HEVC NAL unit types
  localparam logic [5:0] HEVC_BLA_W_LP   = 6'd16;
  localparam logic [5:0] HEVC_BLA_W_RADL = 6'd17;
  localparam logic [5:0] HEVC_BLA_N_LP   = 6'd18;
  localparam logic [5:0] HEVC_IDR_W_RADL = 6'd19;
  localparam logic [5:0] HEVC_IDR_N_LP   = 6'd20;
  localparam logic [5:0] HEVC_CRA        = 6'd21;
  localparam logic [5:0] HEVC_VPS        = 6'd32;
  localparam logic [5:0] HEVC_SPS        = 6'd33;
  localparam logic [5:0] HEVC_PPS        = 6'd34;
  localparam logic [5:0] HEVC_AUD        = 6'd35;
  localparam logic [5:0] HEVC_FD         = 6'd38;
  localparam logic [5:0] HEVC_SEI_PREFIX = 6'd39;

  // SAP classes
  localparam logic [CLS_W-1:0] SAP_NONE  = 2'd0;
  localparam logic [CLS_W-1:0] SAP_CLS_1 = 2'd1;
  localparam logic [CLS_W-1:0] SAP_CLS_2 = 2'd2;
  localparam logic [CLS_W-1:0] SAP_CLS_3 = 2'd3;

  typedef enum logic [1:0] {
    PH_LEN   = 2'd0,
    PH_HDR   = 2'd1,
    PH_SKIP  = 2'd2,
    PH_DRAIN = 2'd3
  } phase_t;

  typedef struct packed {
    logic [CNT_W-1:0] length_field_bytes;
    logic             hevc_mode;
  } cfg_t;

  typedef struct packed {
    logic             skip;
    logic [CLS_W-1:0] sap_class;
  } hdr_cls_t;

  function automatic hdr_cls_t classify(input logic [DATA_W-1:0] hdr, input logic hevc);
    hdr_cls_t r;
    logic [5:0] ht;
    logic [4:0] at;
    r  = '{skip: 1'b0, sap_class: SAP_NONE};
    ht = hdr[6:1];
    at = hdr[4:0];
    if (hevc) begin
      case (ht)
        HEVC_CRA: r.sap_class = SAP_CLS_3;
        HEVC_IDR_N_LP, HEVC_BLA_N_LP: r.sap_class = SAP_CLS_1;
        HEVC_IDR_W_RADL, HEVC_BLA_W_RADL, HEVC_BLA_W_LP: r.sap_class = SAP_CLS_2;
        HEVC_AUD, HEVC_FD, HEVC_SEI_PREFIX, HEVC_VPS, HEVC_SPS, HEVC_PPS: r.skip = 1'b1;
        default: r.sap_class = SAP_NONE;
      endcase
    end else begin
      case (at)
        AVC_IDR: r.sap_class = SAP_CLS_1;
        AVC_AUD, AVC_FILLER, AVC_SEI: r.skip = 1'b1;
        default: r.sap_class = SAP_NONE;
      endcase
    end
    return r;
  endfunction

endpackage

// ===== rtl/nal_sample_sap_classifier.sv =====
// Top level: input item register, NAL parser and result register.
//
// Usage:
//   Sample bytes enter on in_data_byte / in_last_byte, one per accepted item
//   (in_valid high, in_stall low at a rising edge). Each sample yields exactly
//   one sap_class item on the out_ channel, on the byte that decides it or on
//   the sample's last byte; bytes that decide nothing give no result.
//   Configuration (prefix size, header mode) is written over the cfg_ APB port;
//   the user must write it only while the block is idle; the block has no check for this; pready is always high.
// Pipeline: an accepted byte waits in the input register; its result is loaded into
//   the output register, which drives out_valid, when the byte advances past a free output.
// Throughput: one byte per cycle while in_stall is low; the parser updates prefix/skip counters
//   with one 32-bit decrement or shift per byte.
// Stall: a result held by out_stall stays in the output register while one
//   more byte can wait in the input register; a second result-bearing byte
//   then raises in_stall. Bytes with no result keep flowing past a stalled
//   output.
// Reset: synchronous, active low; clears parse state and both valid flags,
//   prefix size returns to 4 and header mode to AVC.
module nal_sample_sap_classifier import nssc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [DATA_W-1:0]     in_data_byte,
  input  logic                  in_last_byte,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [CLS_W-1:0]      out_sap_class,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [APB_ADDR_W-1:0] cfg_paddr,
  input  logic [APB_DATA_W-1:0] cfg_pwdata,
  output logic [APB_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  cfg_t              cfg;
  logic              s1_valid_r, s1_valid_nxt;
  logic [DATA_W-1:0] s1_data_r;
  logic              s1_last_r;
  logic              out_valid_r, out_valid_nxt;
  logic [CLS_W-1:0]  out_class_r;
  logic              res_valid;
  logic [CLS_W-1:0]  res_class;
  logic              out_free;
  logic              s1_adv;
  logic              in_acc;

  nssc_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  nssc_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (s1_adv),
    .data_byte (s1_data_r),
    .last_byte (s1_last_r),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res_class (res_class)
  );

  assign out_free = !out_valid_r || !out_stall;
  // an item with no result advances even while the output is held
  assign s1_adv   = s1_valid_r && (out_free || !res_valid);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt  = in_acc || (s1_valid_r && !s1_adv);
    out_valid_nxt = out_valid_r;
    if (s1_adv && res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_data_r <= in_data_byte;
      s1_last_r <= in_last_byte;
    end
    if (s1_adv && res_valid) begin
      out_class_r <= res_class;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_sap_class = out_class_r;

`ifndef NO_ASSERTIONS
  a_held_item_stays: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_adv |=> s1_valid_r && $stable(s1_data_r) && $stable(s1_last_r))
    else $error("held input item lost or changed");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && res_valid |-> out_free)
    else $error("result written over an unread result");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && res_valid |=> out_valid_r && out_class_r == $past(res_class))
    else $error("result not captured");
`endif

endmodule

// ===== rtl/nssc_cfg_regs.sv =====
// APB configuration registers: prefix size and header mode.
module nssc_cfg_regs import nssc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [APB_ADDR_W-1:0] cfg_paddr,
  input  logic [APB_DATA_W-1:0] cfg_pwdata,
  output logic [APB_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready,
  output cfg_t                  cfg
);

  logic [CNT_W-1:0] lfb_r;
  logic             hevc_r;
  logic             wr_en;
  logic             sel;

  assign cfg_pready = 1'b1;
  assign sel        = cfg_paddr[2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lfb_r  <= LFB_RESET;
      hevc_r <= 1'b0;
    end else if (wr_en) begin
      case (sel)
        REG_LENGTH_FIELD_BYTES: lfb_r  <= cfg_pwdata[CNT_W-1:0];
        REG_HEVC_MODE:          hevc_r <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      REG_LENGTH_FIELD_BYTES: cfg_prdata = {{(APB_DATA_W-CNT_W){1'b0}}, lfb_r};
      REG_HEVC_MODE:          cfg_prdata = {{(APB_DATA_W-1){1'b0}}, hevc_r};
      default:                cfg_prdata = '0;
    endcase
  end

  assign cfg.length_field_bytes = lfb_r;
  assign cfg.hevc_mode          = hevc_r;

endmodule

// ===== rtl/nssc_parser.sv =====
// Per-sample NAL parse state: length prefix, header decision, skip and drain.
module nssc_parser import nssc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [DATA_W-1:0] data_byte,
  input  logic              last_byte,
  input  cfg_t              cfg,
  output logic              res_valid,
  output logic [CLS_W-1:0]  res_class
);

  phase_t           phase_r, phase_nxt;
  logic [LEN_W-1:0] accum_r, accum_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [LEN_W-1:0] skip_r, skip_nxt;
  logic             dec_r, dec_nxt;

  logic [CNT_W-1:0] lfb;
  logic             lfb_zero;
  logic [CNT_W-1:0] cnt_inc;
  logic [LEN_W-1:0] accum_dec;
  logic [LEN_W-1:0] skip_dec;
  logic [LEN_W-1:0] hdr_bytes;
  hdr_cls_t         hc;
  logic             decide;

  assign lfb       = (cfg.length_field_bytes > MAX_LENGTH_BYTES) ? MAX_LENGTH_BYTES
                                                                 : cfg.length_field_bytes;
  assign lfb_zero  = (lfb == '0);
  assign cnt_inc   = cnt_r + 3'd1;
  assign accum_dec = accum_r - 32'd1;
  assign skip_dec  = skip_r - 32'd1;
  assign hdr_bytes = cfg.hevc_mode ? 32'd2 : 32'd1;
  assign hc        = classify(data_byte, cfg.hevc_mode);

  // outputs: decision on this byte, or a forced class 0 at an undecided end
  always_comb begin
    decide    = !dec_r && (lfb_zero || (phase_r == PH_HDR && !hc.skip));
    res_valid = decide || (last_byte && !dec_r);
    res_class = (decide && !lfb_zero) ? hc.sap_class : SAP_NONE;
  end

  // next state
  always_comb begin
    phase_nxt = phase_r;
    accum_nxt = accum_r;
    cnt_nxt   = cnt_r;
    skip_nxt  = skip_r;
    dec_nxt   = dec_r;
    if (!dec_r) begin
      if (decide) begin
        dec_nxt   = 1'b1;
        phase_nxt = PH_DRAIN;
      end else begin
        case (phase_r)
          PH_LEN: begin
            accum_nxt = {accum_r[LEN_W-DATA_W-1:0], data_byte};
            if (cnt_inc >= lfb) begin
              cnt_nxt   = '0;
              phase_nxt = PH_HDR;
            end else begin
              cnt_nxt = cnt_inc;
            end
          end
          PH_HDR: begin
            // skipped unit; one shorter than its header drains the sample
            if (accum_r < hdr_bytes) begin
              phase_nxt = PH_DRAIN;
            end else begin
              skip_nxt  = accum_dec;
              phase_nxt = (accum_dec != '0) ? PH_SKIP : PH_LEN;
            end
            accum_nxt = '0;
          end
          PH_SKIP: begin
            skip_nxt = skip_dec;
            if (skip_dec == '0) begin
              accum_nxt = '0;
              phase_nxt = PH_LEN;
            end
          end
          default: ;
        endcase
      end
    end
    if (last_byte) begin
      phase_nxt = PH_LEN;
      accum_nxt = '0;
      cnt_nxt   = '0;
      skip_nxt  = '0;
      dec_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LEN;
      accum_r <= '0;
      cnt_r   <= '0;
      skip_r  <= '0;
      dec_r   <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      accum_r <= accum_nxt;
      cnt_r   <= cnt_nxt;
      skip_r  <= skip_nxt;
      dec_r   <= dec_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_decided_drains: assert property (@(posedge clk) disable iff (!rst_n)
    dec_r |-> phase_r == PH_DRAIN)
    else $error("decided sample not in drain phase");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    step && last_byte |=> phase_r == PH_LEN && !dec_r && cnt_r == '0)
    else $error("sample state not cleared after last byte");

  a_one_per_sample: assert property (@(posedge clk) disable iff (!rst_n)
    dec_r |-> !decide)
    else $error("second decision within one sample");
`endif

endmodule

// ===== tb/sv/nssc_checker.sv =====
// Checker for the SAP classifier: predicts sap_class per sample and compares results.
module nssc_checker import nssc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [DATA_W-1:0]     in_data_byte,
  input  logic                  in_last_byte,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [CLS_W-1:0]      out_sap_class,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [APB_ADDR_W-1:0] cfg_paddr,
  input  logic [APB_DATA_W-1:0] cfg_pwdata,
  input  logic                  cfg_pready,
  output int unsigned           fail_count,
  output int unsigned           pending_count,
  output int unsigned           class_count
);

  // shadow registers
  logic [CNT_W-1:0] lfb_reg;
  logic             hevc_reg;

  // parser state of the current sample
  phase_t           stage;
  logic [LEN_W-1:0] len_acc;
  logic [CNT_W-1:0] pfx_count;
  logic [LEN_W-1:0] skip_left;
  logic             sample_decided;

  logic [CLS_W-1:0] sap_expected_q[$];
  int unsigned      fails;
  int unsigned      results_seen;

  function automatic void clear_sample();
    stage          = PH_LEN;
    len_acc        = '0;
    pfx_count      = '0;
    skip_left      = '0;
    sample_decided = 1'b0;
  endfunction

  // -1 means the unit is skipped
  function automatic int hdr_class(input logic [DATA_W-1:0] hdr);
    int c;
    c = 0;
    if (hevc_reg) begin
      case (hdr[6:1])
        HEVC_CRA:                                      c = int'(SAP_CLS_3);
        HEVC_IDR_N_LP, HEVC_BLA_N_LP:                  c = int'(SAP_CLS_1);
        HEVC_IDR_W_RADL, HEVC_BLA_W_RADL, HEVC_BLA_W_LP: c = int'(SAP_CLS_2);
        HEVC_VPS, HEVC_SPS, HEVC_PPS, HEVC_AUD, HEVC_FD, HEVC_SEI_PREFIX: c = -1;
        default:                                       c = int'(SAP_NONE);
      endcase
    end else begin
      case (hdr[4:0])
        AVC_IDR:                      c = int'(SAP_CLS_1);
        AVC_AUD, AVC_FILLER, AVC_SEI: c = -1;
        default:                      c = int'(SAP_NONE);
      endcase
    end
    return c;
  endfunction

  // advance the parser by one byte; returns 1 when the byte yields a result
  function automatic bit parse_byte(input logic [DATA_W-1:0] b, input logic lb,
                                    output logic [CLS_W-1:0] cls);
    logic [CNT_W-1:0] eff;
    logic [LEN_W-1:0] hdr_bytes;
    bit               emit;
    int               c;
    emit = 1'b0;
    cls  = SAP_NONE;
    eff  = (lfb_reg > MAX_LENGTH_BYTES) ? MAX_LENGTH_BYTES : lfb_reg;
    if (!sample_decided) begin
      if (eff == 0) begin
        emit           = 1'b1;
        sample_decided = 1'b1;
        stage          = PH_DRAIN;
      end else begin
        case (stage)
          PH_LEN: begin
            len_acc   = {len_acc[LEN_W-9:0], b};
            pfx_count = pfx_count + 1'b1;
            if (pfx_count >= eff) begin
              pfx_count = '0;
              stage     = PH_HDR;
            end
          end
          PH_HDR: begin
            c = hdr_class(b);
            if (c >= 0) begin
              cls            = c[CLS_W-1:0];
              emit           = 1'b1;
              sample_decided = 1'b1;
              stage          = PH_DRAIN;
            end else begin
              hdr_bytes = hevc_reg ? 2 : 1;
              // unit shorter than its header runs to the end of the sample
              if (len_acc < hdr_bytes) begin
                stage = PH_DRAIN;
              end else begin
                skip_left = len_acc - 1;
                stage     = (skip_left != 0) ? PH_SKIP : PH_LEN;
              end
              len_acc = '0;
            end
          end
          PH_SKIP: begin
            skip_left = skip_left - 1;
            if (skip_left == 0) begin
              len_acc = '0;
              stage   = PH_LEN;
            end
          end
          default: ;
        endcase
      end
    end
    if (lb) begin
      if (!sample_decided && !emit) begin
        cls  = SAP_NONE;
        emit = 1'b1;
      end
      clear_sample();
    end
    return emit;
  endfunction

  always @(posedge clk) begin : watch
    logic [CLS_W-1:0] cls;
    logic [CLS_W-1:0] want;
    if (!rst_n) begin
      lfb_reg  = LFB_RESET;
      hevc_reg = 1'b0;
      clear_sample();
      sap_expected_q.delete();
      fails        = 0;
      results_seen = 0;
    end else begin
      // results first, so a result can never match an item taken at this edge
      if (out_valid && !out_stall) begin
        if (sap_expected_q.size() == 0) begin
          if (fails < 10)
            $display("[%0t] unexpected sap_class %0d, no sample result pending",
                     $time, out_sap_class);
          fails++;
        end else begin
          want = sap_expected_q.pop_front();
          if (out_sap_class !== want) begin
            if (fails < 10)
              $display("[%0t] sap_class mismatch on result %0d: expected %0d, got %0d",
                       $time, results_seen, want, out_sap_class);
            fails++;
          end
          results_seen++;
        end
      end
      if (in_valid && !in_stall) begin
        if (parse_byte(in_data_byte, in_last_byte, cls))
          sap_expected_q.push_back(cls);
      end
      // a register write takes effect for the following byte
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        if (cfg_paddr[2] == REG_HEVC_MODE)
          hevc_reg = cfg_pwdata[0];
        else
          lfb_reg = cfg_pwdata[CNT_W-1:0];
      end
    end
    fail_count    <= fails;
    pending_count <= sap_expected_q.size();
    class_count   <= results_seen;
  end

endmodule

// ===== tb/sv/nal_sample_sap_classifier_tb.sv =====
// Testbench top: clock, reset, sample stimulus, config writes and verdict.
module nal_sample_sap_classifier_tb;
  import nssc_pkg::*;

  localparam int unsigned RAND_BYTES     = 1200;
  localparam int unsigned SETTLE         = 4;
  localparam int unsigned WATCHDOG_LIMIT = 3000;

  localparam logic [APB_ADDR_W-1:0] ADDR_LFB  = {REG_LENGTH_FIELD_BYTES, 2'b00};
  localparam logic [APB_ADDR_W-1:0] ADDR_HEVC = {REG_HEVC_MODE, 2'b00};

  logic                  clk          = 1'b0;
  logic                  rst_n        = 1'b0;
  logic                  in_valid     = 1'b0;
  logic                  in_stall;
  logic [DATA_W-1:0]     in_data_byte = '0;
  logic                  in_last_byte = 1'b0;
  logic                  out_valid;
  logic                  out_stall    = 1'b0;
  logic [CLS_W-1:0]      out_sap_class;
  logic                  cfg_psel     = 1'b0;
  logic                  cfg_penable  = 1'b0;
  logic                  cfg_pwrite   = 1'b0;
  logic [APB_ADDR_W-1:0] cfg_paddr    = '0;
  logic [APB_DATA_W-1:0] cfg_pwdata   = '0;
  logic [APB_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  int unsigned fail_count;
  int unsigned pending_count;
  int unsigned class_count;

  // config sweep for the first random phases; extremes included
  int unsigned LFB_SEQ [10] = '{1, 4, 2, 3, 0, 7, 1, 5, 4, 6};
  bit          HEVC_SEQ[10] = '{0, 1, 1, 0, 1, 0, 1, 1, 0, 0};

  logic [DATA_W-1:0] sample_q[$];
  int unsigned       bytes_sent;
  int unsigned       samples_sent;
  int unsigned       phases_run;
  int unsigned       pfx_bytes;   // effective prefix size for building samples
  bit                cur_hevc;
  bit                burst_mode;
  int unsigned       quiet;

  always #2 clk = ~clk;

  nal_sample_sap_classifier dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data_byte  (in_data_byte),
    .in_last_byte  (in_last_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_sap_class (out_sap_class),
    .cfg_psel      (cfg_psel),
    .cfg_penable   (cfg_penable),
    .cfg_pwrite    (cfg_pwrite),
    .cfg_paddr     (cfg_paddr),
    .cfg_pwdata    (cfg_pwdata),
    .cfg_prdata    (cfg_prdata),
    .cfg_pready    (cfg_pready)
  );

  nssc_checker chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data_byte  (in_data_byte),
    .in_last_byte  (in_last_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_sap_class (out_sap_class),
    .cfg_psel      (cfg_psel),
    .cfg_penable   (cfg_penable),
    .cfg_pwrite    (cfg_pwrite),
    .cfg_paddr     (cfg_paddr),
    .cfg_pwdata    (cfg_pwdata),
    .cfg_pready    (cfg_pready),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .class_count   (class_count)
  );

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic logic [5:0] pick_type();
    int unsigned r;
    logic [5:0]  t;
    r = $urandom_range(0, 99);
    if (cur_hevc) begin
      if (r < 40) begin
        case ($urandom_range(0, 5))
          0:       t = HEVC_VPS;
          1:       t = HEVC_SPS;
          2:       t = HEVC_PPS;
          3:       t = HEVC_AUD;
          4:       t = HEVC_FD;
          default: t = HEVC_SEI_PREFIX;
        endcase
      end else if (r < 75) begin
        t = HEVC_BLA_W_LP + 6'($urandom_range(0, 5));
      end else begin
        t = 6'($urandom);
      end
    end else begin
      if (r < 40) begin
        case ($urandom_range(0, 2))
          0:       t = {1'b0, AVC_AUD};
          1:       t = {1'b0, AVC_FILLER};
          default: t = {1'b0, AVC_SEI};
        endcase
      end else if (r < 75) begin
        t = {1'b0, AVC_IDR};
      end else begin
        t = 6'($urandom);
      end
    end
    return t;
  endfunction

  function automatic int unsigned pick_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8)  return $urandom_range(0, 2);
    if (r < 96) return $urandom_range(cur_hevc ? 2 : 1, 9);
    return $urandom_range(20, 300);
  endfunction

  // prefix, header and payload of one NAL unit; the prefix may truncate ulen
  task automatic put_unit(input logic [5:0] ntype, input int unsigned ulen);
    int unsigned hdr_bytes;
    hdr_bytes = cur_hevc ? 2 : 1;
    for (int i = int'(pfx_bytes) - 1; i >= 0; i--)
      sample_q.push_back(8'(ulen >> (8 * i)));
    if (cur_hevc) begin
      sample_q.push_back({1'($urandom), ntype, 1'($urandom)});
      sample_q.push_back(8'($urandom));
    end else begin
      sample_q.push_back({3'($urandom), ntype[4:0]});
    end
    for (int unsigned i = hdr_bytes; i < ulen; i++)
      sample_q.push_back(8'($urandom));
  endtask

  task automatic build_sample();
    int unsigned kind;
    int unsigned cut;
    sample_q.delete();
    kind = $urandom_range(0, 99);
    if (pfx_bytes == 0 || kind >= 90) begin
      // noise
      repeat ($urandom_range(1, 12)) sample_q.push_back(8'($urandom));
    end else begin
      repeat ($urandom_range(1, 4)) put_unit(pick_type(), pick_len());
      if (kind >= 75) begin
        cut = $urandom_range(1, sample_q.size());
        while (sample_q.size() > cut) void'(sample_q.pop_back());
      end
    end
  endtask

  task automatic send_byte(input logic [DATA_W-1:0] b, input logic lb);
    int unsigned gap;
    gap = burst_mode ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= lb;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  // close = 0 leaves the sample open for a later continuation
  task automatic send_sample(input bit close);
    burst_mode = ($urandom_range(0, 4) == 0);
    foreach (sample_q[i])
      send_byte(sample_q[i], close && (i == sample_q.size() - 1));
    if (close) samples_sent++;
  endtask

  task automatic wait_results_done();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [APB_ADDR_W-1:0] addr,
                           input logic [APB_DATA_W-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // upper data bits are random; only the register's own bits matter
  task automatic set_config(input logic [CNT_W-1:0] lfb, input logic hevc);
    wait_results_done();
    cfg_write(ADDR_LFB, ($urandom & ~32'h7) | lfb);
    cfg_write(ADDR_HEVC, ($urandom & ~32'h1) | hevc);
    pfx_bytes = 32'((lfb > MAX_LENGTH_BYTES) ? MAX_LENGTH_BYTES : lfb);
    cur_hevc  = hevc;
    phases_run++;
  endtask

  initial begin : rx_pace
    int unsigned run_len;
    int unsigned hold_len;
    forever begin
      run_len  = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
      hold_len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
      if (run_len > 0) begin
        out_stall <= 1'b0;
        repeat (run_len) @(posedge clk);
      end
      out_stall <= 1'b1;
      repeat (hold_len) @(posedge clk);
    end
  end

  // ends the run if no item moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("[%0t] watchdog: no item moved for %0d cycles", $time, quiet);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned rand_start;
    bytes_sent   = 0;
    samples_sent = 0;
    phases_run   = 0;
    pfx_bytes    = 32'(LFB_RESET);
    cur_hevc     = 1'b0;
    burst_mode   = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset config: 4-byte prefix, AVC IDR
    sample_q = '{8'h00, 8'h00, 8'h00, 8'h01, 8'h65};
    send_sample(1'b1);
    // no length prefix: first byte decides
    set_config(3'd0, 1'b0);
    sample_q = '{8'hFF};
    send_sample(1'b1);
    // oversize prefix clamps to 4; HEVC CRA decided on first header byte
    set_config(3'd7, 1'b1);
    sample_q = '{8'h00, 8'h00, 8'h00, 8'h02, 8'h2A};
    send_sample(1'b1);
    // HEVC VPS unit of length 1, shorter than its header
    set_config(3'd1, 1'b1);
    sample_q = '{8'h01, 8'h40, 8'hFF};
    send_sample(1'b1);
    // AVC: skipped AUD, then the sample ends on the next prefix byte
    set_config(3'd1, 1'b0);
    sample_q = '{8'h02, 8'h09, 8'h10, 8'h00};
    send_sample(1'b1);
    // sample ends right after a prefix
    sample_q = '{8'h03};
    send_sample(1'b1);
    // non-SAP type decides class 0 at once
    sample_q = '{8'h01, 8'hE1, 8'h55};
    send_sample(1'b1);
    // prefix size shrinks mid-sample: the prefix in progress ends at once
    set_config(3'd4, 1'b0);
    sample_q = '{8'h00, 8'h00};
    send_sample(1'b0);
    set_config(3'd2, 1'b0);
    sample_q = '{8'h01, 8'h65};
    send_sample(1'b1);

    rand_start = bytes_sent;
    for (int unsigned ph = 0; bytes_sent - rand_start < RAND_BYTES; ph++) begin
      if (ph < 10)
        set_config(3'(LFB_SEQ[ph]), HEVC_SEQ[ph]);
      else
        set_config(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
      repeat ($urandom_range(6, 12)) begin
        build_sample();
        send_sample(1'b1);
        if ($urandom_range(0, 19) == 0) wait_results_done();
      end
    end

    wait_results_done();
    $display("Sent %0d bytes in %0d samples over %0d config settings (prefix 0..7, AVC/HEVC);",
             bytes_sent, samples_sent, phases_run);
    $display("checked %0d sap_class results, %0d still pending.", class_count, pending_count);
    if (fail_count == 0 && pending_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
